>>> hw/rtl/mdns_pkg.sv
// Shared types, codes and character tables for the datagram to sentence converter.
// No dependencies; every other file refers to it by scoped names.
package mdns_pkg;

    // datagram command codes
    localparam logic [7:0] CMD_DEPTH       = 8'h00;
    localparam logic [7:0] CMD_WIND_ANGLE  = 8'h10;
    localparam logic [7:0] CMD_WIND_SPEED  = 8'h11;
    localparam logic [7:0] CMD_WATER_SPEED = 8'h20;

    // characters
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER  = 8'h37;   // 'A' - 10
    localparam logic [7:0] CH_METRE  = 8'h4D;   // 'M'

    // binary to decimal conversion
    localparam int BIN_W      = 28;
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int NUM_DIGITS = 6;
    localparam int NUM_W      = 4 * NUM_DIGITS;
    localparam int POS_W      = 3;
    // metres in tenths: drop the four low decimal digits of raw * 3048
    localparam int DROP_DIGITS = 4;
    localparam logic [BIN_W-1:0] FEET_TO_METRES = BIN_W'(3048);

    typedef enum logic [1:0] {
        K_MWV,
        K_DBT,
        K_VHW
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               metric;
        logic [NUM_W-1:0]   num1;
        logic [NUM_W-1:0]   num2;
        logic [POS_W-1:0]   lead1;
        logic [POS_W-1:0]   lead2;
    } t_job;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_PRE,
        BE_NUM,
        BE_DOT,
        BE_FRAC,
        BE_MID,
        BE_POST,
        BE_STAR,
        BE_HEX_HI,
        BE_HEX_LO,
        BE_CR,
        BE_LF
    } t_be_state;

    typedef enum logic [1:0] {
        SEG_PRE,
        SEG_MID,
        SEG_POST
    } t_seg;

    // fixed text of all three sentences, first character in the top byte
    localparam int LIT_LEN   = 47;
    localparam int LIT_IDX_W = 6;
    localparam logic [8*LIT_LEN-1:0] LIT_TEXT =
        "$INMWV,,T,,K,A$INDBT,,f,,M,,F$INVHW,,T,,M,,N,,K";

    function automatic logic [7:0] lit_char(input logic [LIT_IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(idx) < LIT_LEN) begin
            ch = LIT_TEXT[8*(LIT_LEN-1-int'(idx)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [LIT_IDX_W-1:0] seg_start(input t_kind k, input t_seg s);
        logic [LIT_IDX_W-1:0] r;
        r = '0;
        case (k)
            K_MWV: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(0);
                    SEG_MID:  r = LIT_IDX_W'(7);
                    default:  r = LIT_IDX_W'(10);
                endcase
            end
            K_DBT: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(14);
                    SEG_MID:  r = LIT_IDX_W'(21);
                    default:  r = LIT_IDX_W'(24);
                endcase
            end
            default: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(29);
                    default:  r = LIT_IDX_W'(42);
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [LIT_IDX_W-1:0] seg_last(input t_kind k, input t_seg s);
        logic [LIT_IDX_W-1:0] r;
        r = '0;
        case (k)
            K_MWV: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(6);
                    SEG_MID:  r = LIT_IDX_W'(9);
                    default:  r = LIT_IDX_W'(13);
                endcase
            end
            K_DBT: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(20);
                    SEG_MID:  r = LIT_IDX_W'(23);
                    default:  r = LIT_IDX_W'(28);
                endcase
            end
            default: begin
                case (s)
                    SEG_PRE:  r = LIT_IDX_W'(41);
                    default:  r = LIT_IDX_W'(46);
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CH_ZERO + {4'h0, d};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] ch;
        if (v <= 4'd9) begin
            ch = CH_ZERO + {4'h0, v};
        end else begin
            ch = CH_UPPER + {4'h0, v};
        end
        return ch;
    endfunction

    // highest non-zero whole digit; the units digit always prints
    function automatic logic [POS_W-1:0] lead_pos(input logic [NUM_W-1:0] n);
        logic [POS_W-1:0] p;
        p = POS_W'(1);
        for (int i = 2; i < NUM_DIGITS; i++) begin
            if (n[4*i +: 4] != 4'h0) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/mdns_bcd.sv
// Shift-and-add-3 binary to BCD converter, one input bit per step.
// Depends on mdns_pkg for the widths.
module mdns_bcd (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [mdns_pkg::BIN_W-1:0]   i_value,
    output logic [mdns_pkg::BCD_W-1:0]   o_digits
);

    logic [mdns_pkg::BIN_W-1:0] r_bin;
    logic [mdns_pkg::BIN_W-1:0] n_bin;
    logic [mdns_pkg::BCD_W-1:0] r_bcd;
    logic [mdns_pkg::BCD_W-1:0] n_bcd;
    logic [mdns_pkg::BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < mdns_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
        n_bcd = r_bcd;
        n_bin = r_bin;
        if (i_load) begin
            n_bcd = '0;
            n_bin = i_value;
        end else if (i_step) begin
            n_bcd = {adj[mdns_pkg::BCD_W-2:0], r_bin[mdns_pkg::BIN_W-1]};
            n_bin = {r_bin[mdns_pkg::BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_digits = r_bcd;

endmodule

>>> hw/rtl/mdns_front.sv
// Front end: takes datagrams, keeps the wind state and converts the numbers to decimal.
// Depends on mdns_pkg and mdns_bcd; hands finished jobs to the job queue.
module mdns_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_command_byte,
    input  logic [7:0]           i_data_byte_a,
    input  logic [7:0]           i_data_byte_b,
    input  logic [7:0]           i_data_byte_c,
    output logic                 o_job_push,
    input  logic                 i_job_full,
    output mdns_pkg::t_job       o_job
);

    localparam int CNT_W = $clog2(mdns_pkg::BIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mdns_pkg::BIN_W - 1);

    mdns_pkg::t_fe_state r_state;
    mdns_pkg::t_fe_state n_state;
    logic [CNT_W-1:0]    r_cnt;
    mdns_pkg::t_kind     r_kind;
    logic [15:0]         r_angle;
    logic [6:0]          r_whole;
    logic [3:0]          r_tenths;
    logic                r_metric;

    logic                        accept;
    logic                        known;
    mdns_pkg::t_kind             kind;
    logic [mdns_pkg::BIN_W-1:0]  val1;
    logic [mdns_pkg::BIN_W-1:0]  val2;
    logic                        conv_load;
    logic                        conv_step;
    logic [mdns_pkg::BCD_W-1:0]  dig1;
    logic [mdns_pkg::BCD_W-1:0]  dig2;
    logic [mdns_pkg::NUM_W-1:0]  num1;
    logic [mdns_pkg::NUM_W-1:0]  num2;

    assign accept = i_push && !o_full;

    // values in tenths; angle halves times five gives tenths of a degree
    always_comb begin
        known = 1'b1;
        kind  = mdns_pkg::K_MWV;
        val1  = '0;
        val2  = '0;
        case (i_command_byte)
            mdns_pkg::CMD_WIND_ANGLE: begin
                val1 = mdns_pkg::BIN_W'({i_data_byte_a, i_data_byte_b}) * mdns_pkg::BIN_W'(5);
                val2 = mdns_pkg::BIN_W'(r_whole) * mdns_pkg::BIN_W'(10)
                     + mdns_pkg::BIN_W'(r_tenths);
            end
            mdns_pkg::CMD_WIND_SPEED: begin
                val1 = mdns_pkg::BIN_W'(r_angle) * mdns_pkg::BIN_W'(5);
                val2 = mdns_pkg::BIN_W'(i_data_byte_a[6:0]) * mdns_pkg::BIN_W'(10)
                     + mdns_pkg::BIN_W'(i_data_byte_b[3:0]);
            end
            mdns_pkg::CMD_DEPTH: begin
                kind = mdns_pkg::K_DBT;
                val1 = mdns_pkg::BIN_W'({i_data_byte_b, i_data_byte_c});
                val2 = mdns_pkg::BIN_W'({i_data_byte_b, i_data_byte_c})
                     * mdns_pkg::FEET_TO_METRES;
            end
            mdns_pkg::CMD_WATER_SPEED: begin
                kind = mdns_pkg::K_VHW;
                val1 = mdns_pkg::BIN_W'({i_data_byte_a, i_data_byte_b});
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign conv_load = accept && known;

    mdns_bcd u_bcd1 (
        .i_clk    (i_clk),
        .i_load   (conv_load),
        .i_step   (conv_step),
        .i_value  (val1),
        .o_digits (dig1)
    );

    mdns_bcd u_bcd2 (
        .i_clk    (i_clk),
        .i_load   (conv_load),
        .i_step   (conv_step),
        .i_value  (val2),
        .o_digits (dig2)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdns_pkg::FE_IDLE: begin
                if (conv_load) begin
                    n_state = mdns_pkg::FE_CONV;
                end
            end
            mdns_pkg::FE_CONV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = mdns_pkg::FE_PUSH;
                end
            end
            mdns_pkg::FE_PUSH: begin
                if (!i_job_full) begin
                    n_state = mdns_pkg::FE_IDLE;
                end
            end
            default: begin
                n_state = mdns_pkg::FE_IDLE;
            end
        endcase
    end

    always_comb begin
        o_full     = (r_state != mdns_pkg::FE_IDLE);
        conv_step  = (r_state == mdns_pkg::FE_CONV);
        o_job_push = (r_state == mdns_pkg::FE_PUSH);
    end

    // metres keep only the digits above the dropped ones
    always_comb begin
        num1 = dig1[mdns_pkg::NUM_W-1:0];
        if (r_kind == mdns_pkg::K_DBT) begin
            num2 = mdns_pkg::NUM_W'(dig2[mdns_pkg::BCD_W-1:4*mdns_pkg::DROP_DIGITS]);
        end else begin
            num2 = dig2[mdns_pkg::NUM_W-1:0];
        end
        o_job.kind   = r_kind;
        o_job.metric = r_metric;
        o_job.num1   = num1;
        o_job.num2   = num2;
        o_job.lead1  = mdns_pkg::lead_pos(num1);
        o_job.lead2  = mdns_pkg::lead_pos(num2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mdns_pkg::FE_IDLE;
            r_cnt    <= '0;
            r_angle  <= '0;
            r_whole  <= '0;
            r_tenths <= '0;
            r_metric <= 1'b0;
        end else begin
            r_state <= n_state;
            if (conv_load) begin
                r_cnt <= '0;
            end else if (conv_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (accept && i_command_byte == mdns_pkg::CMD_WIND_ANGLE) begin
                r_angle <= {i_data_byte_a, i_data_byte_b};
            end
            if (accept && i_command_byte == mdns_pkg::CMD_WIND_SPEED) begin
                r_whole  <= i_data_byte_a[6:0];
                r_tenths <= i_data_byte_b[3:0];
                r_metric <= i_data_byte_a[7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_load) begin
            r_kind <= kind;
        end
    end

endmodule

>>> hw/rtl/mdns_jobq.sv
// Short job queue between the front end and the sentence sequencer.
// Depends on mdns_pkg for the job type.
module mdns_jobq #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mdns_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output mdns_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mdns_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> hw/rtl/mdns_back.sv
// Sentence sequencer: spells out a job and checksum a character per cycle unless stalled.
// Depends on mdns_pkg; drives the result register seen at the top level.
module mdns_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    input  mdns_pkg::t_job  i_job,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_text_byte,
    output logic            o_last_of_sentence
);

    mdns_pkg::t_be_state               r_state;
    mdns_pkg::t_be_state               n_state;
    mdns_pkg::t_job                    r_job;
    logic [mdns_pkg::LIT_IDX_W-1:0]    r_idx;
    logic [mdns_pkg::POS_W-1:0]        r_pos;
    logic                              r_second;
    logic [7:0]                        r_sum;
    logic                              r_ovalid;
    logic [7:0]                        r_otext;
    logic                              r_olast;

    logic                              adv;
    logic [7:0]                        ch;
    logic                              ch_last;
    logic                              ch_sum;
    mdns_pkg::t_seg                    seg;
    logic                              seg_end;
    logic [mdns_pkg::NUM_W-1:0]        num;

    assign adv = (r_state != mdns_pkg::BE_IDLE) && (!r_ovalid || i_pop);

    always_comb begin
        case (r_state)
            mdns_pkg::BE_PRE: seg = mdns_pkg::SEG_PRE;
            mdns_pkg::BE_MID: seg = mdns_pkg::SEG_MID;
            default:          seg = mdns_pkg::SEG_POST;
        endcase
        seg_end = (r_idx == mdns_pkg::seg_last(r_job.kind, seg));
        num     = r_second ? r_job.num2 : r_job.num1;
    end

    // character for the current step
    always_comb begin
        ch        = 8'h00;
        ch_last   = 1'b0;
        ch_sum    = 1'b0;
        o_job_pop = (r_state == mdns_pkg::BE_IDLE) && !i_job_empty;
        case (r_state)
            mdns_pkg::BE_PRE, mdns_pkg::BE_MID, mdns_pkg::BE_POST: begin
                ch = mdns_pkg::lit_char(r_idx);
                // unit letter of the wind sentence
                if (r_state == mdns_pkg::BE_POST && r_job.kind == mdns_pkg::K_MWV
                        && r_job.metric
                        && r_idx == mdns_pkg::seg_start(mdns_pkg::K_MWV, mdns_pkg::SEG_POST)
                                    + mdns_pkg::LIT_IDX_W'(1)) begin
                    ch = mdns_pkg::CH_METRE;
                end
                ch_sum = (ch != mdns_pkg::CH_DOLLAR);
            end
            mdns_pkg::BE_NUM: begin
                ch     = mdns_pkg::digit_char(num[4*r_pos +: 4]);
                ch_sum = 1'b1;
            end
            mdns_pkg::BE_DOT: begin
                ch     = mdns_pkg::CH_DOT;
                ch_sum = 1'b1;
            end
            mdns_pkg::BE_FRAC: begin
                ch     = mdns_pkg::digit_char(num[3:0]);
                ch_sum = 1'b1;
            end
            mdns_pkg::BE_STAR:   ch = mdns_pkg::CH_STAR;
            mdns_pkg::BE_HEX_HI: ch = mdns_pkg::hex_char(r_sum[7:4]);
            mdns_pkg::BE_HEX_LO: ch = mdns_pkg::hex_char(r_sum[3:0]);
            mdns_pkg::BE_CR:     ch = mdns_pkg::CH_CR;
            mdns_pkg::BE_LF: begin
                ch      = mdns_pkg::CH_LF;
                ch_last = 1'b1;
            end
            default: begin
                ch = 8'h00;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdns_pkg::BE_IDLE: begin
                if (!i_job_empty) begin
                    n_state = mdns_pkg::BE_PRE;
                end
            end
            mdns_pkg::BE_PRE: begin
                if (adv && seg_end) n_state = mdns_pkg::BE_NUM;
            end
            mdns_pkg::BE_NUM: begin
                if (adv && r_pos == mdns_pkg::POS_W'(1)) n_state = mdns_pkg::BE_DOT;
            end
            mdns_pkg::BE_DOT: begin
                if (adv) n_state = mdns_pkg::BE_FRAC;
            end
            mdns_pkg::BE_FRAC: begin
                if (adv) n_state = r_second ? mdns_pkg::BE_POST : mdns_pkg::BE_MID;
            end
            mdns_pkg::BE_MID: begin
                if (adv && seg_end) begin
                    n_state = (r_job.kind == mdns_pkg::K_VHW) ? mdns_pkg::BE_STAR
                                                              : mdns_pkg::BE_NUM;
                end
            end
            mdns_pkg::BE_POST: begin
                if (adv && seg_end) n_state = mdns_pkg::BE_STAR;
            end
            mdns_pkg::BE_STAR: begin
                if (adv) n_state = mdns_pkg::BE_HEX_HI;
            end
            mdns_pkg::BE_HEX_HI: begin
                if (adv) n_state = mdns_pkg::BE_HEX_LO;
            end
            mdns_pkg::BE_HEX_LO: begin
                if (adv) n_state = mdns_pkg::BE_CR;
            end
            mdns_pkg::BE_CR: begin
                if (adv) n_state = mdns_pkg::BE_LF;
            end
            mdns_pkg::BE_LF: begin
                if (adv) n_state = mdns_pkg::BE_IDLE;
            end
            default: begin
                n_state = mdns_pkg::BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mdns_pkg::BE_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job    <= i_job;
            r_idx    <= mdns_pkg::seg_start(i_job.kind, mdns_pkg::SEG_PRE);
            r_sum    <= 8'h00;
            r_second <= 1'b0;
        end else if (adv) begin
            if (ch_sum) begin
                r_sum <= r_sum ^ ch;
            end
            r_otext <= ch;
            r_olast <= ch_last;
            case (r_state)
                mdns_pkg::BE_PRE: begin
                    if (seg_end) r_pos <= r_job.lead1;
                    else         r_idx <= r_idx + mdns_pkg::LIT_IDX_W'(1);
                end
                mdns_pkg::BE_MID: begin
                    if (seg_end) begin
                        r_second <= 1'b1;
                        r_pos    <= r_job.lead2;
                    end else begin
                        r_idx <= r_idx + mdns_pkg::LIT_IDX_W'(1);
                    end
                end
                mdns_pkg::BE_POST: begin
                    r_idx <= r_idx + mdns_pkg::LIT_IDX_W'(1);
                end
                mdns_pkg::BE_NUM: begin
                    r_pos <= r_pos - mdns_pkg::POS_W'(1);
                end
                mdns_pkg::BE_FRAC: begin
                    r_idx <= mdns_pkg::seg_start(r_job.kind,
                                 r_second ? mdns_pkg::SEG_POST : mdns_pkg::SEG_MID);
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_empty            = !r_ovalid;
    assign o_text_byte        = r_otext;
    assign o_last_of_sentence = r_olast;

endmodule

>>> hw/rtl/marine_datagram_to_nmea_sentence_core.sv
// Top level of the datagram to NMEA sentence converter.
// Depends on mdns_pkg, mdns_front, mdns_jobq and mdns_back.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------------------
//  datagram  | in        | push / full         | command_byte, data_byte_a, _b, _c
//  sentence  | out       | pop / empty         | text_byte, last_of_sentence
//
// A known datagram keeps full high after the cycle that takes it, through 28 binary to
// decimal steps (one bit per cycle through two converters), then a push state that hands the job
// over and lasts while the job queue has no room. Unknown commands are taken without raising full.
// The sequencer then gives one character per cycle (up to 32, after an idle state that loads a job)
// while pop keeps up; a stalled pop holds the character and halts the sequencer only.
// Reset clears the wind state and all queues; no clearing pass.
module marine_datagram_to_nmea_sentence_core #(
    parameter int JOB_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_command_byte,
    input  logic [7:0]  i_data_byte_a,
    input  logic [7:0]  i_data_byte_b,
    input  logic [7:0]  i_data_byte_c,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_text_byte,
    output logic        o_last_of_sentence
);

    mdns_pkg::t_job fe_job;
    mdns_pkg::t_job q_job;
    logic           fe_push;
    logic           q_full;
    logic           q_empty;
    logic           be_pop;

    mdns_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command_byte (i_command_byte),
        .i_data_byte_a  (i_data_byte_a),
        .i_data_byte_b  (i_data_byte_b),
        .i_data_byte_c  (i_data_byte_c),
        .o_job_push     (fe_push),
        .i_job_full     (q_full),
        .o_job          (fe_job)
    );

    mdns_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_job   (fe_job),
        .o_full  (q_full),
        .i_pop   (be_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    mdns_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_empty        (q_empty),
        .o_job_pop          (be_pop),
        .i_job              (q_job),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_text_byte        (o_text_byte),
        .o_last_of_sentence (o_last_of_sentence)
    );

endmodule

>>> hw/rtl/mdns_checker.sv
// Port-level checks for the datagram to sentence converter, bound to the top level.
// Depends on mdns_pkg for character codes.
module mdns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_command_byte,
    input logic [7:0]  i_data_byte_a,
    input logic [7:0]  i_data_byte_b,
    input logic [7:0]  i_data_byte_c,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_text_byte,
    input logic        o_last_of_sentence
);

    // nothing to show straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_text_byte) && $stable(o_last_of_sentence)))
        else $error("stalled item changed");

    // line feed only ever closes a sentence, and the last item is always the line feed
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_of_sentence == (o_text_byte == mdns_pkg::CH_LF)))
        else $error("last flag and line feed disagree");

    // only printable text, CR and LF
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_text_byte == mdns_pkg::CH_CR || o_text_byte == mdns_pkg::CH_LF
                    || (o_text_byte >= 8'h20 && o_text_byte <= 8'h7E)))
        else $error("non-printable character");

endmodule

bind marine_datagram_to_nmea_sentence_core mdns_checker u_mdns_checker (.*);
